@@ sv/lsf_pkg.sv @@
// Shared constants, types and the sine table entry function of the
// windowed sinc weight block. No dependencies.
package lsf_pkg;

    // Fixed-point format of offsets, widths and weight
    localparam int LSF_FRAC_BITS    = 16;
    localparam int LSF_SINE_ENTRIES = 1024;

    localparam int OFF_W  = 22;
    localparam int INV_W  = 19;
    localparam int TAU_W  = 16;
    localparam int WGT_W  = 18;
    localparam int CFG_W  = 19;
    localparam int U_W    = LSF_FRAC_BITS + 3;
    localparam int PH_W   = 40;
    localparam int DEN_W  = 41;
    localparam int MAG_W  = 33;
    localparam int SINC_W = 33;
    localparam int FACT_W = 36;
    localparam int OUTER_SH = 32 - LSF_FRAC_BITS;
    localparam int INNER_SH = 20 - LSF_FRAC_BITS;

    // Pipeline depths
    localparam int DIV_STEPS = 32;
    localparam int SINC_LAT  = 4 + DIV_STEPS + 1;
    localparam int AXIS_LAT  = 3 + SINC_LAT + 2;
    localparam int LSF_LAT   = AXIS_LAT + 2;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        REG_INV_X = 2'd0,
        REG_INV_Y = 2'd1,
        REG_LOBES = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic zero;
        logic beyond;
    } t_axis_flags;

    // sin(a) in Q30 by a truncated Taylor series, a in Q30 radians
    function automatic logic [30:0] f_sine_entry(input logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        a2 = (a * a) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((a2 * t) >> 30) / 64'd110);
        t  = Q30_ONE - (((a2 * t) >> 30) / 64'd72);
        t  = Q30_ONE - (((a2 * t) >> 30) / 64'd42);
        t  = Q30_ONE - (((a2 * t) >> 30) / 64'd20);
        t  = Q30_ONE - (((a2 * t) >> 30) / 64'd6);
        s  = (a * t) >> 30;
        return s[30:0];
    endfunction

endpackage

@@ sv/lsf_sine_rom.sv @@
// Quarter-wave sine table with per-entry slope, registered read.
// Depends on lsf_pkg.
module lsf_sine_rom #(
    parameter int ENTRIES = lsf_pkg::LSF_SINE_ENTRIES,
    localparam int IdxW = $clog2(ENTRIES + 1)
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [IdxW-1:0]     i_idx,
    output logic [30:0]         o_base,
    output logic signed [31:0]  o_delta
);
    import lsf_pkg::*;

    logic [30:0]        w_base  [ENTRIES+1];
    logic signed [31:0] w_delta [ENTRIES+1];
    logic [30:0]        r_base;
    logic signed [31:0] r_delta;

    // Build table entries at elaboration
    for (genvar k = 0; k <= ENTRIES; k++) begin : g_ent
        localparam logic [63:0] AK  = HALF_PI_Q30 * 64'(k) / 64'(ENTRIES);
        localparam logic [63:0] AK1 = HALF_PI_Q30 * 64'(k + 1) / 64'(ENTRIES);
        localparam logic [30:0] B0  = f_sine_entry(AK);
        localparam logic [30:0] B1  = f_sine_entry(AK1);
        assign w_base[k] = B0;
        if (k < ENTRIES) begin : g_slope
            assign w_delta[k] = $signed({1'b0, B1}) - $signed({1'b0, B0});
        end else begin : g_last
            assign w_delta[k] = '0;
        end
    end

    // Registered read, held on stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_base  <= w_base[i_idx];
            r_delta <= w_delta[i_idx];
        end
    end

    assign o_base  = r_base;
    assign o_delta = r_delta;

endmodule

@@ sv/lsf_sinc.sv @@
// Pipelined sinc: sin(pi*p)/(pi*p) in Q30 from a half-turn phase, with
// table sine, interpolation and a restoring divider. Depends on lsf_pkg, lsf_sine_rom.
module lsf_sinc #(
    parameter int ENTRIES = lsf_pkg::LSF_SINE_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [lsf_pkg::PH_W-1:0]          i_phase,
    output logic signed [lsf_pkg::SINC_W-1:0] o_sinc
);
    import lsf_pkg::*;

    localparam int IdxW = $clog2(ENTRIES + 1);
    localparam int SW   = 34 + IdxW;

    // Stage A: fold into first quadrant, table position, denominator partials
    logic [31:0]   w_f_fold;
    logic [SW-1:0] n_s;
    logic [55:0]   n_m1;
    logic [47:0]   n_m2;
    logic [SW-1:0] r_a_s;
    logic          r_a_neg;
    logic [55:0]   r_a_m1;
    logic [47:0]   r_a_m2;

    always_comb begin
        w_f_fold = (i_phase[31:0] > 32'h8000_0000) ?
                   32'(33'h1_0000_0000 - {1'b0, i_phase[31:0]}) : i_phase[31:0];
        n_s  = SW'(w_f_fold) * SW'(2 * ENTRIES);
        n_m1 = 56'(PI_Q30[31:0]) * 56'(i_phase[PH_W-1:16]);
        n_m2 = 48'(PI_Q30[31:0]) * 48'(i_phase[15:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_s   <= n_s;
            r_a_neg <= i_phase[32];
            r_a_m1  <= n_m1;
            r_a_m2  <= n_m2;
        end
    end

    // Stage B: clamp index, issue table read, finish denominator
    logic [SW-33:0]    w_idx_raw;
    logic [IdxW-1:0]   w_idx;
    logic [15:0]       w_r;
    logic [56:0]       w_den_sum;
    logic [15:0]       r_b_r;
    logic              r_b_neg;
    logic [DEN_W-1:0]  r_b_den;
    logic              r_b_dz;
    logic [30:0]       w_rom_base;
    logic signed [31:0] w_rom_delta;

    always_comb begin
        w_idx_raw = r_a_s[SW-1:32];
        if (w_idx_raw >= (SW-32)'(ENTRIES)) begin
            w_idx = IdxW'(ENTRIES);
            w_r   = '0;
        end else begin
            w_idx = w_idx_raw[IdxW-1:0];
            w_r   = r_a_s[31:16];
        end
        w_den_sum = 57'(r_a_m1) + 57'(r_a_m2[47:16]);
    end

    lsf_sine_rom #(.ENTRIES(ENTRIES)) u_rom (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_idx   (w_idx),
        .o_base  (w_rom_base),
        .o_delta (w_rom_delta)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_r   <= w_r;
            r_b_neg <= r_a_neg;
            r_b_den <= w_den_sum[56:16];
            r_b_dz  <= (w_den_sum[56:16] == '0);
        end
    end

    // Stage C: interpolation product
    logic [30:0]        r_c_base;
    logic signed [48:0] r_c_prod;
    logic               r_c_neg;
    logic [DEN_W-1:0]   r_c_den;
    logic               r_c_dz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_base <= w_rom_base;
            r_c_prod <= w_rom_delta * $signed({1'b0, r_b_r});
            r_c_neg  <= r_b_neg;
            r_c_den  <= r_b_den;
            r_c_dz   <= r_b_dz;
        end
    end

    // Stage D: sine value with sign, split into sign and magnitude
    logic signed [48:0] w_padj;
    logic signed [33:0] w_v;
    logic signed [33:0] w_sin;
    logic [MAG_W-1:0]   r_d_mag;
    logic               r_d_sgn;
    logic [DEN_W-1:0]   r_d_den;
    logic               r_d_dz;

    always_comb begin
        w_padj = r_c_prod + (r_c_prod[48] ? 49'sd65535 : 49'sd0);
        w_v    = $signed({3'b000, r_c_base}) + 34'(w_padj >>> 16);
        w_sin  = r_c_neg ? -w_v : w_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_sgn <= w_sin[33];
            r_d_mag <= MAG_W'(w_sin[33] ? -w_sin : w_sin);
            r_d_den <= r_c_den;
            r_d_dz  <= r_c_dz;
        end
    end

    // Divider: one quotient bit per stage of |sin| * 2^30 / den
    logic [DEN_W:0]       r_rem [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_q   [DIV_STEPS];
    logic [DEN_W-1:0]     r_den [DIV_STEPS];
    logic [1:0]           r_dl  [DIV_STEPS];
    logic                 r_sgn [DIV_STEPS];
    logic                 r_dz  [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [DEN_W:0]       w_rem_in;
        logic [DIV_STEPS-1:0] w_q_in;
        logic [DEN_W-1:0]     w_den_in;
        logic [1:0]           w_dl_in;
        logic                 w_sgn_in;
        logic                 w_dz_in;
        logic [DEN_W+1:0]     w_shift;
        logic [DEN_W+1:0]     w_diff;
        logic                 w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = (DEN_W+1)'(r_d_mag >> 2);
            assign w_q_in   = '0;
            assign w_den_in = r_d_den;
            assign w_dl_in  = r_d_mag[1:0];
            assign w_sgn_in = r_d_sgn;
            assign w_dz_in  = r_d_dz;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_q_in   = r_q[j-1];
            assign w_den_in = r_den[j-1];
            assign w_dl_in  = r_dl[j-1];
            assign w_sgn_in = r_sgn[j-1];
            assign w_dz_in  = r_dz[j-1];
        end

        assign w_shift = {w_rem_in, w_dl_in[1]};
        assign w_diff  = w_shift - {2'b00, w_den_in};
        assign w_ge    = (w_shift >= {2'b00, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? w_diff[DEN_W:0] : w_shift[DEN_W:0];
                r_q[j]   <= {w_q_in[DIV_STEPS-2:0], w_ge};
                r_den[j] <= w_den_in;
                r_dl[j]  <= {w_dl_in[0], 1'b0};
                r_sgn[j] <= w_sgn_in;
                r_dz[j]  <= w_dz_in;
            end
        end
    end

    // Apply sign; vanishing argument gives the limit value one
    logic signed [SINC_W-1:0] w_qs;
    logic signed [SINC_W-1:0] r_out;

    always_comb begin
        w_qs = $signed({1'b0, r_q[DIV_STEPS-1]});
        if (r_dz[DIV_STEPS-1]) begin
            w_qs = $signed(SINC_W'(Q30_ONE));
        end else if (r_sgn[DIV_STEPS-1]) begin
            w_qs = -$signed({1'b0, r_q[DIV_STEPS-1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= w_qs;
        end
    end

    assign o_sinc = r_out;

endmodule

@@ sv/lsf_axis.sv @@
// One axis of the separable weight: scale, window test, two sinc terms
// and their product in Q30. Depends on lsf_pkg, lsf_sinc.
module lsf_axis #(
    parameter int ENTRIES = lsf_pkg::LSF_SINE_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [lsf_pkg::OFF_W-1:0]  i_offset,
    input  logic [lsf_pkg::INV_W-1:0]         i_inv,
    input  logic [lsf_pkg::TAU_W-1:0]         i_lobes,
    output logic signed [lsf_pkg::FACT_W-1:0] o_factor
);
    import lsf_pkg::*;

    localparam int PROD_W = OFF_W + INV_W;
    localparam int V_W    = U_W + TAU_W;
    localparam int FLG_N  = SINC_LAT + 3;
    localparam logic [U_W-1:0] U_LIMIT = {U_W{1'b1}};
    localparam logic [U_W-1:0] U_ONE   = U_W'(1) << LSF_FRAC_BITS;

    // Stage 1: magnitude times inverse width
    logic [OFF_W-1:0]  w_mag;
    logic [PROD_W-1:0] r1_prod;

    assign w_mag = i_offset[OFF_W-1] ? OFF_W'(-i_offset) : OFF_W'(i_offset);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= PROD_W'(w_mag) * PROD_W'(i_inv);
        end
    end

    // Stage 2: saturate u, classify, scale by lobe count
    logic [PROD_W-LSF_FRAC_BITS-1:0] w_ush;
    logic [U_W-1:0]    w_u;
    t_axis_flags       n_flg;
    logic [U_W-1:0]    r2_u;
    logic [V_W-1:0]    r2_v;
    t_axis_flags       r_flg [FLG_N];

    always_comb begin
        w_ush = r1_prod[PROD_W-1:LSF_FRAC_BITS];
        w_u   = (w_ush > (PROD_W-LSF_FRAC_BITS)'(U_LIMIT)) ? U_LIMIT : w_ush[U_W-1:0];
        n_flg.zero   = (w_u == '0);
        n_flg.beyond = (w_u > U_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_u <= w_u;
            r2_v <= V_W'(w_u) * V_W'(i_lobes);
        end
    end

    // Carry window flags alongside the sinc pipelines
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flg[0] <= n_flg;
            for (int i = 1; i < FLG_N; i++) begin
                r_flg[i] <= r_flg[i-1];
            end
        end
    end

    // Stage 3: phases in half-turns
    logic [PH_W-1:0] r3_p_out;
    logic [PH_W-1:0] r3_p_in;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p_out <= PH_W'(r2_u) << OUTER_SH;
            r3_p_in  <= PH_W'(r2_v) << INNER_SH;
        end
    end

    logic signed [SINC_W-1:0] w_inner;
    logic signed [SINC_W-1:0] w_outer;

    lsf_sinc #(.ENTRIES(ENTRIES)) u_sinc_in (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_phase (r3_p_in),
        .o_sinc  (w_inner)
    );

    lsf_sinc #(.ENTRIES(ENTRIES)) u_sinc_out (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_phase (r3_p_out),
        .o_sinc  (w_outer)
    );

    // Product of the two sinc terms, then Q30 rescale toward zero
    logic signed [2*SINC_W-1:0] r4_prod;
    logic signed [2*SINC_W-1:0] w_adj;
    logic signed [FACT_W-1:0]   r5_fact;
    t_axis_flags                w_flg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_prod <= w_inner * w_outer;
        end
    end

    always_comb begin
        w_flg = r_flg[FLG_N-1];
        w_adj = r4_prod + (r4_prod[2*SINC_W-1] ?
                (2*SINC_W)'(64'd1073741823) : (2*SINC_W)'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            priority if (w_flg.zero) begin
                r5_fact <= $signed(FACT_W'(Q30_ONE));
            end else if (w_flg.beyond) begin
                r5_fact <= '0;
            end else begin
                r5_fact <= FACT_W'(w_adj >>> 30);
            end
        end
    end

    assign o_factor = r5_fact;

endmodule

@@ sv/lanczos_sinc_filter_weight.sv @@
// Lanczos-windowed sinc filter weight, top level: configuration registers,
// two axis pipelines, weight product and output register. Depends on lsf_pkg, lsf_axis.
//
// Usage:
//   s_axis carries one offset pair per item: tdata[21:0] x_offset,
//   tdata[43:22] y_offset (signed Q5.16). m_axis returns one weight per
//   item: tdata[17:0] weight (signed Q1.16). Registers are written through
//   i_cfg_wr_en / i_cfg_addr / i_cfg_wdata while the block is idle:
//   0 inv_x_width, 1 inv_y_width, 2 sinc_lobes.
//   Throughput is one item per cycle while m_axis is not stalled. The path
//   from accept to the weight appearing on m_axis is mostly the 32-step
//   restoring divider in each sinc unit, one quotient bit per stage.
//   All stages share one advance enable: when m_axis holds a weight that
//   is not taken, the whole pipeline and s_axis_tready freeze, so nothing
//   is lost or repeated. Reset clears the valid bits and loads the
//   register defaults (half-width 4, three lobes); the sine table is a
//   constant and needs no fill.
module lanczos_sinc_filter_weight #(
    parameter int SINE_TABLE_ENTRIES = lsf_pkg::LSF_SINE_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,  // x_offset, y_offset, pad
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,  // weight, pad
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_addr,
    input  logic [lsf_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import lsf_pkg::*;

    localparam int WP_W = 2 * FACT_W;
    localparam int WT_W = WP_W - 44;

    // Configuration registers
    logic [INV_W-1:0] r_inv_x;
    logic [INV_W-1:0] r_inv_y;
    logic [TAU_W-1:0] r_lobes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_x <= INV_W'(16384);
            r_inv_y <= INV_W'(16384);
            r_lobes <= TAU_W'(12288);
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_INV_X: r_inv_x <= i_cfg_wdata[INV_W-1:0];
                REG_INV_Y: r_inv_y <= i_cfg_wdata[INV_W-1:0];
                REG_LOBES: r_lobes <= i_cfg_wdata[TAU_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output item is stalled
    logic                w_en;
    logic [LSF_LAT-1:0]  r_vld;

    assign w_en          = !r_vld[LSF_LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LSF_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LSF_LAT-2:0], s_axis_tvalid};
        end
    end

    logic signed [FACT_W-1:0] w_fx;
    logic signed [FACT_W-1:0] w_fy;

    lsf_axis #(.ENTRIES(SINE_TABLE_ENTRIES)) u_axis_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_offset ($signed(s_axis_tdata[OFF_W-1:0])),
        .i_inv    (r_inv_x),
        .i_lobes  (r_lobes),
        .o_factor (w_fx)
    );

    lsf_axis #(.ENTRIES(SINE_TABLE_ENTRIES)) u_axis_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_offset ($signed(s_axis_tdata[2*OFF_W-1:OFF_W])),
        .i_inv    (r_inv_y),
        .i_lobes  (r_lobes),
        .o_factor (w_fy)
    );

    // Weight product, rescale toward zero by 2^44, saturate
    logic signed [WP_W-1:0]  r_wprod;
    logic signed [WP_W-1:0]  w_wadj;
    logic signed [WT_W-1:0]  w_wt;
    logic signed [WGT_W-1:0] w_wsat;
    logic signed [WGT_W-1:0] r_weight;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wprod <= w_fx * w_fy;
        end
    end

    always_comb begin
        w_wadj = r_wprod + (r_wprod[WP_W-1] ?
                 WP_W'(64'h0000_0FFF_FFFF_FFFF) : WP_W'(0));
        w_wt   = WT_W'(w_wadj >>> 44);
        priority if (w_wt > WT_W'(131071)) begin
            w_wsat = WGT_W'(131071);
        end else if (w_wt < -$signed(WT_W'(131072))) begin
            w_wsat = -$signed(WGT_W'(131072));
        end else begin
            w_wsat = w_wt[WGT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_weight <= w_wsat;
        end
    end

    assign m_axis_tdata = {6'b000000, r_weight};

`ifndef SYNTHESIS
    // A stalled output item blocks new input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // An accepted item enters the first valid stage
    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted item not tracked");

    // Empty output stage never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // Stalled pipeline keeps its valid bits
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during stall");
`endif

endmodule
